// File: rtl/bit_stuffing_frame_encoder_defines.svh
// assertion macros shared by the encoder rtl
`ifndef BIT_STUFFING_FRAME_ENCODER_DEFINES_SVH
`define BIT_STUFFING_FRAME_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define BSFE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication, disabled in reset
`define BSFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`else

`define BSFE_ASSERT_NOW(label, clk, rst, ante, cons)
`define BSFE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/bsfe_pkg.sv
`timescale 1ns / 1ps

package bsfe_pkg;

  localparam int CRC_W      = 32;
  localparam int FLAG_W     = 8;
  localparam int FLAG_IDX_W = $clog2(FLAG_W);
  localparam int CRC_IDX_W  = $clog2(CRC_W);
  localparam int CNT_W      = $clog2(FLAG_W + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = FLAG_W;

  localparam logic [CRC_W-1:0]  CRC_POLY   = 32'hFFFF_FFFF;
  localparam logic [FLAG_W-1:0] FLAG_RESET = 8'h40;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_STUFF  = 3'd1,
    KIND_FLAG   = 3'd2,
    KIND_END    = 3'd3,
    KIND_CRC    = 3'd4,
    KIND_PARITY = 3'd5
  } bit_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PARITY_ODD   = 1'b0,
    CFG_FLAG_PATTERN = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic              parity_odd;
    logic [FLAG_W-1:0] flag_pattern;
  } cfg_t;

  // one classified request handed from front to back
  typedef struct packed {
    logic              data_bit;
    logic              stuff;
    logic              last;
    logic              parity;
    logic [FLAG_W-1:0] flag;
    logic [CRC_W-1:0]  crc;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/bsfe_if.sv
`timescale 1ns / 1ps

interface bsfe_in_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic last_bit;

  modport source (output valid, output data_bit, output last_bit, input ready);
  modport sink   (input valid, input data_bit, input last_bit, output ready);
endinterface

interface bsfe_out_if;
  logic       valid;
  logic       ready;
  logic       out_bit;
  logic [2:0] bit_kind;
  logic       frame_end;

  modport source (output valid, output out_bit, output bit_kind, output frame_end,
                  input ready);
  modport sink   (input valid, input out_bit, input bit_kind, input frame_end,
                  output ready);
endinterface

// File: rtl/bsfe_fifo.sv
`timescale 1ns / 1ps
`include "bit_stuffing_frame_encoder_defines.svh"

module bsfe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign rd_data = mem[rd_ptr];
  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `BSFE_ASSERT_NOW(a_no_push_full, clk, rst, push, !full || pop)
  `BSFE_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, !empty)
  `BSFE_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

// File: rtl/bsfe_front.sv
`timescale 1ns / 1ps

module bsfe_front
  import bsfe_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  bsfe_in_if.sink       in_ch,
  input  logic          q_full,
  output logic          push,
  output entry_t        entry
);

  logic [CRC_W-1:0]  crc;
  logic              parity_acc;
  logic [FLAG_W-1:0] recent_bits;
  logic [CNT_W-1:0]  recent_count;

  logic [CRC_W-1:0]  crc_next;
  logic [FLAG_W-1:0] win1;
  logic [CNT_W-1:0]  cnt1;
  logic              stuff;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    crc_next = {crc[CRC_W-2:0], 1'b0} ^ (CRC_POLY & {CRC_W{crc[CRC_W-1] ^ in_ch.data_bit}});
    win1     = {recent_bits[FLAG_W-2:0], in_ch.data_bit};
    cnt1     = (recent_count == CNT_W'(FLAG_W)) ? recent_count : recent_count + 1'b1;
    stuff    = (cnt1 == CNT_W'(FLAG_W)) && (win1 == cfg.flag_pattern);

    entry.data_bit = in_ch.data_bit;
    entry.stuff    = stuff;
    entry.last     = in_ch.last_bit;
    entry.parity   = parity_acc ^ in_ch.data_bit ^ cfg.parity_odd;
    entry.flag     = cfg.flag_pattern;
    entry.crc      = crc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc          <= '0;
      parity_acc   <= 1'b0;
      recent_bits  <= '0;
      recent_count <= '0;
    end else if (push) begin
      if (in_ch.last_bit) begin
        crc          <= '0;
        parity_acc   <= 1'b0;
        recent_bits  <= '0;
        recent_count <= '0;
      end else begin
        crc          <= crc_next;
        parity_acc   <= parity_acc ^ in_ch.data_bit;
        // count already saturated whenever a stuffed zero goes in
        recent_bits  <= stuff ? {win1[FLAG_W-2:0], 1'b0} : win1;
        recent_count <= cnt1;
      end
    end
  end

endmodule

// File: rtl/bsfe_back.sv
`timescale 1ns / 1ps
`include "bit_stuffing_frame_encoder_defines.svh"

module bsfe_back
  import bsfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  entry_t      head,
  input  logic        head_valid,
  output logic        pop,
  bsfe_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    PH_DATA, PH_STUFF, PH_FLAG, PH_END, PH_CRC, PH_PARITY
  } phase_t;

  phase_t               phase;
  phase_t               phase_next;
  logic [CRC_IDX_W-1:0] idx;
  logic [CRC_IDX_W-1:0] idx_next;
  logic                 out_valid;
  logic                 out_bit;
  bit_kind_t            out_kind;
  logic                 out_end;

  logic      fire;
  logic      done;
  logic      cur_bit;
  bit_kind_t cur_kind;

  assign fire = head_valid && (!out_valid || out_ch.ready);
  assign pop  = fire && done;

  always_comb begin
    phase_next = phase;
    idx_next   = idx;
    done       = 1'b0;
    cur_bit    = 1'b0;
    cur_kind   = KIND_DATA;
    unique case (phase)
      PH_DATA: begin
        cur_bit  = head.data_bit;
        cur_kind = KIND_DATA;
        if (head.stuff) begin
          phase_next = PH_STUFF;
        end else if (head.last) begin
          phase_next = PH_FLAG;
          idx_next   = CRC_IDX_W'(FLAG_W - 1);
        end else begin
          done = 1'b1;
        end
      end
      PH_STUFF: begin
        cur_bit  = 1'b0;
        cur_kind = KIND_STUFF;
        if (head.last) begin
          phase_next = PH_FLAG;
          idx_next   = CRC_IDX_W'(FLAG_W - 1);
        end else begin
          phase_next = PH_DATA;
          done       = 1'b1;
        end
      end
      PH_FLAG: begin
        cur_bit  = head.flag[idx[FLAG_IDX_W-1:0]];
        cur_kind = KIND_FLAG;
        if (idx == '0) begin
          phase_next = PH_END;
        end else begin
          idx_next = idx - 1'b1;
        end
      end
      PH_END: begin
        cur_bit    = 1'b1;
        cur_kind   = KIND_END;
        phase_next = PH_CRC;
        idx_next   = CRC_IDX_W'(CRC_W - 1);
      end
      PH_CRC: begin
        cur_bit  = head.crc[idx];
        cur_kind = KIND_CRC;
        if (idx == '0) begin
          phase_next = PH_PARITY;
        end else begin
          idx_next = idx - 1'b1;
        end
      end
      PH_PARITY: begin
        cur_bit    = head.parity;
        cur_kind   = KIND_PARITY;
        phase_next = PH_DATA;
        done       = 1'b1;
      end
      default: begin
        phase_next = PH_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DATA;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        phase     <= phase_next;
        idx       <= idx_next;
        out_valid <= 1'b1;
        out_bit   <= cur_bit;
        out_kind  <= cur_kind;
        out_end   <= (phase == PH_PARITY);
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.out_bit   = out_bit;
  assign out_ch.bit_kind  = out_kind;
  assign out_ch.frame_end = out_end;

  `BSFE_ASSERT_NOW(a_busy_has_head, clk, rst, phase != PH_DATA, head_valid)
  `BSFE_ASSERT_NEXT(a_parity_closes, clk, rst, fire && (phase == PH_PARITY), out_valid && out_end)
  `BSFE_ASSERT_NOW(a_flag_idx, clk, rst, phase == PH_FLAG, idx < CRC_IDX_W'(FLAG_W))

endmodule

// File: rtl/bit_stuffing_frame_encoder.sv
`timescale 1ns / 1ps

// Bit-stuffing transmit framer. Payload bits come in one request at a time,
// msb first, with last_bit on the final bit of a frame; each goes out as a
// data line bit. Once eight line bits of the frame have gone out and the last
// eight equal flag_pattern, a stuffed zero follows the data bit (at most one
// per data bit). After the last bit the trailer is sent: the eight flag bits,
// a one as end marker, the 32-bit crc of the unstuffed data (generator of 33
// ones, init 0, msb first) and the parity bit with frame_end set; frame state
// then clears. Timing: an input request is taken every cycle while the queue
// has room; the output side delivers exactly one line bit per cycle while
// out_ch.ready and a queued request allow. The serialiser behind the
// two-entry queue sets the sustained rate. Write the configuration
// registers only while no frame is in flight.
module bit_stuffing_frame_encoder
  import bsfe_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bsfe_in_if.sink               in_ch,
  bsfe_out_if.source            out_ch
);

  cfg_t   cfg;
  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   q_empty;
  logic   q_full;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.parity_odd   <= 1'b0;
      cfg.flag_pattern <= FLAG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PARITY_ODD:   cfg.parity_odd   <= cfg_data[0];
        CFG_FLAG_PATTERN: cfg.flag_pattern <= cfg_data[FLAG_W-1:0];
        default: ;
      endcase
    end
  end

  // front: crc, parity and stuffing window over the accepted bits
  bsfe_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .entry  (push_entry)
  );

  // queue of classified requests, lets the front run ahead of the line
  bsfe_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_entry),
    .pop     (pop),
    .rd_data (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  // back: serialises data, stuffed zero and trailer into the output register
  bsfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
